[hw/rtl/lttt_pkg.sv]
package lttt_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_REMOVE = 2'd3;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         tween_id;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] dest_x;
    logic signed [31:0] dest_y;
    logic [31:0]        duration;
    logic [31:0]        time_step;
  } req_t;

  typedef struct packed {
    logic [3:0]         assigned_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               done_res;
  } rsp_t;

endpackage

[hw/rtl/linear_tween_table_top.sv]
// Add, remove-all: S_ADD or S_CLR, then S_DONE presents the result.
// Query: S_QRD, S_QMX, S_QMY, S_QAY, S_DONE; one shared multiplier computes x then y.
// Tick: each slot passes S_TRD and S_TEL; a moving slot still short of its duration
// then runs S_TDIV and S_TWR (one that reaches it goes straight to S_TWR), using the
// one-bit-per-cycle restoring divider shared across all slots.
// One transaction at a time; rst (synchronous) clears all slots to zero
// through per-slot valid bits, with no clearing pass.
module linear_tween_table_top
  import lttt_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int SW  = $clog2(SLOTS);
  localparam int FB  = FRAC_BITS;
  localparam int CW  = $clog2(FB + 1);
  localparam int RW  = 192 + FB + 1;
  localparam int PW  = 35 + FB;
  localparam int OSX = 0;
  localparam int OSY = 32;
  localparam int ODX = 64;
  localparam int ODY = 96;
  localparam int ODU = 128;
  localparam int OEL = 160;
  localparam int OFR = 192;
  localparam logic [FB:0] FRAC_ONE = {1'b1, {FB{1'b0}}};

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADD  = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_TRD  = 4'd3;
  localparam logic [3:0] S_TEL  = 4'd4;
  localparam logic [3:0] S_TDIV = 4'd5;
  localparam logic [3:0] S_TWR  = 4'd6;
  localparam logic [3:0] S_QRD  = 4'd7;
  localparam logic [3:0] S_QMX  = 4'd8;
  localparam logic [3:0] S_QMY  = 4'd9;
  localparam logic [3:0] S_QAY  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]       state;
  req_t             req_q;
  rsp_t             res;
  logic [SW-1:0]    next_slot;
  logic [SW-1:0]    idx;
  logic [SLOTS-1:0] valid;
  logic [SLOTS-1:0] active;
  logic [SLOTS-1:0] finished;
  logic             rd_ok;
  logic [RW-1:0]    rdata;
  logic [RW-1:0]    row_rd;
  logic [RW-1:0]    row;
  logic [31:0]      el;
  logic [31:0]      rem;
  logic [FB:0]      quo;
  logic [CW-1:0]    cnt;
  logic signed [PW-1:0] prod;

  logic          we;
  logic [SW-1:0] waddr;
  logic [RW-1:0] wdata;
  logic [SW-1:0] raddr;
  logic [SW-1:0] qidx;
  logic [32:0]   el_sum;
  logic [31:0]   el_sat;
  logic [32:0]   rem2;
  logic          rem_ge;
  logic signed [32:0] diff;
  logic signed [PW-1:0] prod_next;
  logic [31:0]   term;
  logic [4:0]    tid_mod;

  assign req_ready = (state == S_IDLE);
  assign row_rd    = rd_ok ? rdata : '0;

  always_comb begin
    tid_mod = {1'b0, req_q.tween_id};
    if (SLOTS < 16) begin
      for (int k = 0; k < 8; k++) begin
        if (tid_mod >= 5'(SLOTS)) begin
          tid_mod = tid_mod - 5'(SLOTS);
        end
      end
    end
    qidx = SW'(tid_mod);
  end

  assign raddr  = (state == S_QRD) ? qidx : idx;
  assign el_sum = {1'b0, row_rd[OEL+:32]} + {1'b0, req_q.time_step};
  assign el_sat = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
  assign rem2   = {rem, 1'b0};
  assign rem_ge = rem2 >= {1'b0, row[ODU+:32]};
  assign term   = prod[FB+31:FB];

  always_comb begin
    if (state == S_QMX) begin
      diff = 33'(signed'(row_rd[ODX+:32])) - 33'(signed'(row_rd[OSX+:32]));
      prod_next = PW'(diff * signed'({1'b0, row_rd[OFR+:FB+1]}));
    end else begin
      diff = 33'(signed'(row[ODY+:32])) - 33'(signed'(row[OSY+:32]));
      prod_next = PW'(diff * signed'({1'b0, row[OFR+:FB+1]}));
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = row;
    if (state == S_ADD) begin
      we    = 1'b1;
      waddr = next_slot;
      wdata = '0;
      wdata[OSX+:32] = req_q.start_x;
      wdata[OSY+:32] = req_q.start_y;
      wdata[ODX+:32] = req_q.dest_x;
      wdata[ODY+:32] = req_q.dest_y;
      wdata[ODU+:32] = req_q.duration;
    end else if (state == S_TWR) begin
      we = 1'b1;
      wdata[OEL+:32]   = el;
      wdata[OFR+:FB+1] = quo;
    end
  end

  lttt_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      next_slot <= '0;
      idx       <= '0;
      valid     <= '0;
      active    <= '0;
      finished  <= '0;
      rd_ok     <= 1'b0;
      rsp_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      rd_ok <= valid[raddr];
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            res   <= '0;
            idx   <= '0;
            unique case (req.action)
              ACT_ADD:   state <= S_ADD;
              ACT_TICK:  state <= S_TRD;
              ACT_QUERY: state <= S_QRD;
              default:   state <= S_CLR;
            endcase
          end
        end
        S_ADD: begin
          valid[next_slot]    <= 1'b1;
          active[next_slot]   <= 1'b1;
          finished[next_slot] <= 1'b0;
          res.assigned_id     <= 4'(next_slot);
          next_slot <= (next_slot == SW'(SLOTS - 1)) ? '0 : next_slot + 1'b1;
          state <= S_DONE;
        end
        S_CLR: begin
          active <= '0;
          state  <= S_DONE;
        end
        S_TRD: state <= S_TEL;
        S_TEL: begin
          row <= row_rd;
          el  <= el_sat;
          rem <= el_sat;
          cnt <= CW'(FB);
          if (active[idx] && !finished[idx]) begin
            if (el_sat >= row_rd[ODU+:32]) begin
              quo   <= FRAC_ONE;
              state <= S_TWR;
            end else begin
              quo   <= '0;
              state <= S_TDIV;
            end
          end else if (idx == SW'(SLOTS - 1)) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_TRD;
          end
        end
        S_TDIV: begin
          rem <= rem_ge ? 32'(rem2 - {1'b0, row[ODU+:32]}) : rem2[31:0];
          quo <= {quo[FB-1:0], rem_ge};
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            state <= S_TWR;
          end
        end
        S_TWR: begin
          if (el > row[ODU+:32]) begin
            finished[idx] <= 1'b1;
          end
          if (idx == SW'(SLOTS - 1)) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_TRD;
          end
        end
        S_QRD: begin
          idx   <= qidx;
          state <= S_QMX;
        end
        S_QMX: begin
          row          <= row_rd;
          prod         <= prod_next;
          res.done_res <= finished[idx];
          state        <= S_QMY;
        end
        S_QMY: begin
          res.pos_x <= row[OSX+:32] + term;
          prod      <= prod_next;
          state     <= S_QAY;
        end
        S_QAY: begin
          res.pos_y <= row[OSY+:32] + term;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_TDIV) |-> (cnt != '0))
    else $error("divider ran past its last bit");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_TDIV) |-> (rem < row[ODU+:32]))
    else $error("divider remainder not below duration");
  a_frac_max: assert property (@(posedge clk) disable iff (rst)
    (state == S_QMX) |-> (row_rd[OFR+:FB+1] <= FRAC_ONE))
    else $error("stored fraction above one");
`endif

endmodule

[hw/rtl/lttt_ram.sv]
module lttt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[tb/sv/tb_linear_tween_table_top.sv]
`timescale 1ns / 1ps

module tb_linear_tween_table_top;
  import lttt_pkg::*;

  localparam int NSLOT      = SLOTS_DEF;
  localparam int FB         = FRAC_BITS_DEF;
  localparam int N_RANDOM   = 950;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [16:0] FRAC_ONE = 17'(1) << FB;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  linear_tween_table_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  // predicted slot table
  logic [31:0] tw_sx [NSLOT];
  logic [31:0] tw_sy [NSLOT];
  logic [31:0] tw_dx [NSLOT];
  logic [31:0] tw_dy [NSLOT];
  logic [31:0] tw_dur [NSLOT];
  logic [31:0] tw_el [NSLOT];
  logic [16:0] tw_frac [NSLOT];
  bit tw_fin [NSLOT];
  bit tw_act [NSLOT];
  int unsigned tw_next;

  rsp_t pending_rsp[$];
  int errors = 0;
  int n_checked = 0;
  int n_adds = 0, n_ticks = 0, n_queries = 0, n_removes = 0;
  int unsigned cycle = 0;

  req_t dir_req[$];
  rsp_t dir_rsp[$];
  bit dir_typed[$];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d, %0d results pending", cycle, pending_rsp.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] lerp_pos(logic [31:0] s, logic [31:0] d, logic [16:0] f);
    logic signed [63:0] diff;
    logic signed [63:0] prod;
    logic signed [63:0] sum;
    diff = 64'(signed'(d)) - 64'(signed'(s));
    prod = diff * $signed({47'd0, f});
    sum = 64'(signed'(s)) + (prod >>> FB);
    return sum[31:0];
  endfunction

  function automatic void tween_reset();
    for (int i = 0; i < NSLOT; i++) begin
      tw_sx[i] = 0; tw_sy[i] = 0; tw_dx[i] = 0; tw_dy[i] = 0;
      tw_dur[i] = 0; tw_el[i] = 0; tw_frac[i] = 0; tw_fin[i] = 0; tw_act[i] = 0;
    end
    tw_next = 0;
  endfunction

  function automatic rsp_t tween_predict(req_t r);
    rsp_t o;
    logic [63:0] e;
    logic [63:0] q;
    int unsigned s;
    o = '0;
    case (r.action)
      ACT_ADD: begin
        s = tw_next % NSLOT;
        tw_sx[s] = r.start_x; tw_sy[s] = r.start_y;
        tw_dx[s] = r.dest_x; tw_dy[s] = r.dest_y;
        tw_dur[s] = r.duration;
        tw_el[s] = 0; tw_frac[s] = 0; tw_fin[s] = 0; tw_act[s] = 1;
        tw_next = (s + 1) % NSLOT;
        o.assigned_id = 4'(s);
      end
      ACT_TICK: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (tw_act[i] && !tw_fin[i]) begin
            e = 64'(tw_el[i]) + 64'(r.time_step);
            if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
            tw_el[i] = e[31:0];
            if (tw_dur[i] == 0) q = 64'(FRAC_ONE);
            else begin
              q = (e << FB) / 64'(tw_dur[i]);
              if (q > 64'(FRAC_ONE)) q = 64'(FRAC_ONE);
            end
            tw_frac[i] = q[16:0];
            if (e > 64'(tw_dur[i])) tw_fin[i] = 1;
          end
        end
      end
      ACT_QUERY: begin
        s = r.tween_id % NSLOT;
        o.pos_x = lerp_pos(tw_sx[s], tw_dx[s], tw_frac[s]);
        o.pos_y = lerp_pos(tw_sy[s], tw_dy[s], tw_frac[s]);
        o.done_res = tw_fin[s];
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) tw_act[i] = 0;
      end
    endcase
    return o;
  endfunction

  function automatic req_t mk_req(logic [1:0] a, logic [3:0] id, logic [31:0] sx,
                                  logic [31:0] sy, logic [31:0] dx, logic [31:0] dy,
                                  logic [31:0] dur, logic [31:0] stp);
    req_t r;
    r.action = a; r.tween_id = id; r.start_x = sx; r.start_y = sy;
    r.dest_x = dx; r.dest_y = dy; r.duration = dur; r.time_step = stp;
    return r;
  endfunction

  function automatic void row(req_t r, bit typed, rsp_t e);
    dir_req.push_back(r);
    dir_typed.push_back(typed);
    dir_rsp.push_back(e);
  endfunction

  function automatic rsp_t mk_rsp(logic [3:0] id, logic [31:0] x, logic [31:0] y, logic d);
    rsp_t o;
    o.assigned_id = id; o.pos_x = x; o.pos_y = y; o.done_res = d;
    return o;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int unsigned pick;
    r.action = 2'($urandom_range(0, 3));
    r.tween_id = 4'($urandom);
    r.start_x = $urandom; r.start_y = $urandom;
    r.dest_x = $urandom; r.dest_y = $urandom;
    r.duration = $urandom; r.time_step = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 25) r.action = ACT_ADD;
    else if (pick < 57) r.action = ACT_TICK;
    else if (pick < 96) r.action = ACT_QUERY;
    else r.action = ACT_REMOVE;
    pick = $urandom_range(0, 99);
    if (pick < 8) r.duration = 0;
    else if (pick < 85) r.duration = $urandom_range(1, 32'h0008_0000);
    if ($urandom_range(0, 9) != 0) r.time_step = $urandom_range(0, 32'h0002_0000);
    if ($urandom_range(0, 3) == 0) begin
      r.start_x = $signed(16'($urandom)) <<< 8;
      r.dest_x = $signed(16'($urandom)) <<< 8;
    end
    return r;
  endfunction

  function automatic bit quiet_span(int unsigned c);
    return c >= 60000 && c < 140000;
  endfunction

  task automatic send(req_t r, bit typed, rsp_t e);
    rsp_t p;
    while (!quiet_span(cycle) && $urandom_range(0, 99) < 20) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    p = tween_predict(r);
    pending_rsp.push_back(typed ? e : p);
    case (r.action)
      ACT_ADD: n_adds++;
      ACT_TICK: n_ticks++;
      ACT_QUERY: n_queries++;
      default: n_removes++;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= quiet_span(cycle) || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rsp);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        n_checked++;
        if (rsp.assigned_id !== e.assigned_id) begin
          $display("%0t: assigned_id exp %h got %h", $time, e.assigned_id, rsp.assigned_id);
          errors++;
        end
        if (rsp.pos_x !== e.pos_x) begin
          $display("%0t: pos_x exp %h got %h", $time, e.pos_x, rsp.pos_x);
          errors++;
        end
        if (rsp.pos_y !== e.pos_y) begin
          $display("%0t: pos_y exp %h got %h", $time, e.pos_y, rsp.pos_y);
          errors++;
        end
        if (rsp.done_res !== e.done_res) begin
          $display("%0t: done_res exp %b got %b", $time, e.done_res, rsp.done_res);
          errors++;
        end
      end
    end
  end

  initial begin
    rsp_t z;
    int unsigned wait_cnt;
    z = '0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    tween_reset();

    row(mk_req(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0), 1, z);
    row(mk_req(ACT_ADD, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               0, 0), 1, mk_rsp(0, 0, 0, 0));
    row(mk_req(ACT_ADD, 0, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 32'h0004_0000, 0), 1,
        mk_rsp(1, 0, 0, 0));
    row(mk_req(ACT_ADD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'hFFFF_FFFF, 0), 1, mk_rsp(2, 0, 0, 0));
    row(mk_req(ACT_TICK, 0, 0, 0, 0, 0, 0, 32'h0001_0000), 1, z);
    row(mk_req(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0), 1,
        mk_rsp(0, 32'h7FFF_FFFF, 32'h8000_0000, 1));
    row(mk_req(ACT_QUERY, 1, 0, 0, 0, 0, 0, 0), 0, z);
    row(mk_req(ACT_QUERY, 2, 0, 0, 0, 0, 0, 0), 0, z);
    row(mk_req(ACT_TICK, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, z);
    row(mk_req(ACT_TICK, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1, z);
    row(mk_req(ACT_QUERY, 1, 0, 0, 0, 0, 0, 0), 0, z);
    row(mk_req(ACT_QUERY, 2, 0, 0, 0, 0, 0, 0), 0, z);
    row(mk_req(ACT_REMOVE, 0, 0, 0, 0, 0, 0, 0), 1, z);
    row(mk_req(ACT_TICK, 0, 0, 0, 0, 0, 0, 32'h5), 1, z);
    row(mk_req(ACT_QUERY, 2, 0, 0, 0, 0, 0, 0), 0, z);
    row(mk_req(ACT_QUERY, 15, 0, 0, 0, 0, 0, 0), 1, z);
    row(mk_req(ACT_ADD, 0, 32'h0000_1234, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_0001,
               0, 0), 1, mk_rsp(3, 0, 0, 0));
    row(mk_req(ACT_TICK, 0, 0, 0, 0, 0, 0, 0), 1, z);
    row(mk_req(ACT_QUERY, 3, 0, 0, 0, 0, 0, 0), 0, z);
    row(mk_req(ACT_ADD, 0, 32'hFFFF_FFFF, 0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h3, 0), 1,
        mk_rsp(4, 0, 0, 0));
    row(mk_req(ACT_TICK, 0, 0, 0, 0, 0, 0, 32'h1), 1, z);
    row(mk_req(ACT_QUERY, 4, 0, 0, 0, 0, 0, 0), 0, z);
    row(mk_req(ACT_TICK, 0, 0, 0, 0, 0, 0, 32'h3), 1, z);
    row(mk_req(ACT_QUERY, 4, 0, 0, 0, 0, 0, 0), 0, z);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < dir_req.size(); i++) send(dir_req[i], dir_typed[i], dir_rsp[i]);
    for (int i = 0; i < N_RANDOM; i++) send(rand_req(), 0, z);
    req_valid <= 1'b0;

    wait_cnt = 0;
    while (pending_rsp.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (400) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $display("%0d results never arrived", pending_rsp.size());
      errors++;
    end

    $display("checked %0d results: %0d adds, %0d ticks, %0d queries, %0d remove-alls",
             n_checked, n_adds, n_ticks, n_queries, n_removes);
    $display("random stalls on both channels, %0d errors", errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/lttt_pkg.sv
hw/rtl/lttt_ram.sv
hw/rtl/linear_tween_table_top.sv
tb/sv/tb_linear_tween_table_top.sv
